// ===== hdl/dvts_pkg.sv =====
// shared constants and types for the define-value token scanner
// no dependencies

package dvts_pkg;

    localparam int unsigned MAX_LENGTH = 255;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [7:0] POS_MAX = 8'hFF;
    localparam logic [7:0] LEN_MAX = 8'(MAX_LENGTH);

    typedef enum logic [1:0] {
        CLS_PLAIN   = 2'd0,
        CLS_STRING  = 2'd1,
        CLS_LITERAL = 2'd2,
        CLS_BRACKET = 2'd3
    } scan_class_t;

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== hdl/define_value_token_scanner_top.sv =====
// define-value token scanner: splits a character stream into value tokens
// depends on dvts_pkg
//
//  channel | signals                          | direction | meaning
//  char    | char_valid, char_stall, char_in  | in        | one line character per transfer
//  token   | token_valid, token_stall, fields | out       | one finished token per transfer
//
// one character per clock sustained while char_stall is low; token_valid rises once
// the ending character has passed the input register, then the result register
// the scan state updates through short compare/add logic once per character
// char_stall rises only when a token is pending in the result register, the
// consumer stalls and the character held in the input register ends another token
// rst_n clears the scan state and both valid flags at once

module define_value_token_scanner_top
    import dvts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_in,
    output logic       token_valid,
    input  logic       token_stall,
    output logic [7:0] token_start,
    output logic [7:0] token_length,
    output logic [7:0] terminator,
    output logic       token_empty,
    output logic       string_open,
    output logic       line_done
);

    // input register
    logic        in_valid_reg;
    logic [7:0]  char_reg;

    // scan state
    logic        in_token_reg, in_token_next;
    scan_class_t class_reg, class_next;
    logic        escape_reg, escape_next;
    logic [7:0]  raw_reg, raw_next;
    logic [7:0]  trail_reg, trail_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  start_reg, start_next;

    // result register
    logic        out_valid_reg;
    logic [7:0]  res_start_reg, res_length_reg, res_term_reg;
    logic        res_empty_reg, res_sopen_reg, res_done_reg;

    // result of the current character
    logic        emit;
    logic [7:0]  emit_start, emit_length, emit_term;
    logic        emit_empty, emit_sopen, emit_done;

    logic        step_fire;
    logic        char_accept;

    // working values
    logic        white;
    logic        opener;
    logic        take;
    logic [7:0]  base_raw, base_trail;
    logic        base_escape;
    scan_class_t base_class;
    logic [9:0]  len_sum;
    logic [7:0]  pos_inc;

    always_comb
    begin
        white       = is_white(char_reg);
        opener      = (char_reg == CH_DQUOTE) || (char_reg == CH_SQUOTE) ||
                      (char_reg == CH_LPAREN);
        base_raw    = in_token_reg ? raw_reg : 8'd0;
        base_trail  = in_token_reg ? trail_reg : 8'd0;
        base_escape = in_token_reg ? escape_reg : 1'b0;
        base_class  = in_token_reg ? class_reg : CLS_PLAIN;
        pos_inc     = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 8'd1;
        len_sum     = {2'b00, base_raw} + {2'b00, base_trail} + 10'd1;

        in_token_next = in_token_reg;
        class_next    = class_reg;
        escape_next   = escape_reg;
        raw_next      = raw_reg;
        trail_next    = trail_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        take          = 1'b0;

        emit        = 1'b0;
        emit_start  = start_reg;
        emit_length = raw_reg;
        emit_term   = CH_NUL;
        emit_empty  = 1'b0;
        emit_sopen  = 1'b0;
        emit_done   = 1'b0;

        if (char_reg == CH_NUL)
        begin
            emit      = 1'b1;
            emit_done = 1'b1;
            if (in_token_reg)
            begin
                emit_sopen = (class_reg == CLS_STRING);
            end
            else
            begin
                emit_start  = 8'd0;
                emit_length = 8'd0;
                emit_empty  = 1'b1;
            end
            in_token_next = 1'b0;
            class_next    = CLS_PLAIN;
            escape_next   = 1'b0;
            raw_next      = 8'd0;
            trail_next    = 8'd0;
            pos_next      = 8'd0;
            start_next    = 8'd0;
        end
        else if (!in_token_reg && white)
        begin
            pos_next = pos_inc;
        end
        else
        begin
            in_token_next = 1'b1;
            start_next    = in_token_reg ? start_reg : pos_reg;
            escape_next   = base_escape;
            class_next    = base_class;
            raw_next      = base_raw;
            trail_next    = base_trail;
            pos_next      = pos_inc;
            take          = 1'b1;
            if (!in_token_reg && opener)
            begin
                // first character picks the quoting mode
                if (char_reg == CH_DQUOTE)
                    class_next = CLS_STRING;
                else if (char_reg == CH_SQUOTE)
                    class_next = CLS_LITERAL;
                else
                    class_next = CLS_BRACKET;
            end
            else
            begin
                case (base_class)
                    CLS_STRING:
                    begin
                        if (char_reg == CH_BSLASH)
                            escape_next = !base_escape;
                        else
                        begin
                            if ((char_reg == CH_DQUOTE) && !base_escape)
                                class_next = CLS_PLAIN;
                            escape_next = 1'b0;
                        end
                    end
                    CLS_LITERAL:
                    begin
                        if (char_reg == CH_SQUOTE)
                            class_next = CLS_PLAIN;
                    end
                    CLS_BRACKET:
                    begin
                        if (char_reg == CH_RPAREN)
                            class_next = CLS_PLAIN;
                    end
                    default:
                    begin
                        if ((char_reg == CH_SEMI) || (char_reg == CH_COMMA) ||
                            (char_reg == CH_EQUALS))
                        begin
                            emit          = 1'b1;
                            emit_start    = start_next;
                            emit_length   = base_raw;
                            emit_term     = char_reg;
                            in_token_next = 1'b0;
                            escape_next   = 1'b0;
                            raw_next      = 8'd0;
                            trail_next    = 8'd0;
                            take          = 1'b0;
                        end
                    end
                endcase
            end

            if (take)
            begin
                if (white)
                begin
                    if (base_trail != POS_MAX)
                        trail_next = base_trail + 8'd1;
                end
                else
                begin
                    // pending white space counts once a later character follows
                    raw_next   = (len_sum > 10'(MAX_LENGTH)) ? LEN_MAX : len_sum[7:0];
                    trail_next = 8'd0;
                end
            end
        end
    end

    // a character that ends a token needs the result register free
    assign step_fire   = in_valid_reg && (!emit || !out_valid_reg || !token_stall);
    assign char_stall  = in_valid_reg && !step_fire;
    assign char_accept = char_valid && !char_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_token_reg  <= 1'b0;
            class_reg     <= CLS_PLAIN;
            escape_reg    <= 1'b0;
            raw_reg       <= 8'd0;
            trail_reg     <= 8'd0;
            pos_reg       <= 8'd0;
            start_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (char_accept)
                in_valid_reg <= 1'b1;
            else if (step_fire)
                in_valid_reg <= 1'b0;

            if (step_fire)
            begin
                in_token_reg <= in_token_next;
                class_reg    <= class_next;
                escape_reg   <= escape_next;
                raw_reg      <= raw_next;
                trail_reg    <= trail_next;
                pos_reg      <= pos_next;
                start_reg    <= start_next;
            end

            if (step_fire && emit)
                out_valid_reg <= 1'b1;
            else if (!token_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_accept)
            char_reg <= char_in;

        if (step_fire && emit)
        begin
            res_start_reg  <= emit_start;
            res_length_reg <= emit_length;
            res_term_reg   <= emit_term;
            res_empty_reg  <= emit_empty;
            res_sopen_reg  <= emit_sopen;
            res_done_reg   <= emit_done;
        end
    end

    assign token_valid  = out_valid_reg;
    assign token_start  = res_start_reg;
    assign token_length = res_length_reg;
    assign terminator   = res_term_reg;
    assign token_empty  = res_empty_reg;
    assign string_open  = res_sopen_reg;
    assign line_done    = res_done_reg;

endmodule

// ===== tb/tb_define_value_token_scanner_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the define-value token scanner: lines in, tokens out
// depends on dvts_pkg and define_value_token_scanner_top

module tb_define_value_token_scanner_top
    import dvts_pkg::*;
();

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 150;
    localparam int IDLE_PCT      = 8;

    typedef struct packed {
        logic [7:0] start;
        logic [7:0] length;
        logic [7:0] term;
        logic       empty;
        logic       sopen;
        logic       done;
    } token_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       char_valid;
    logic       char_stall;
    logic [7:0] char_in;
    logic       token_valid;
    logic       token_stall;
    logic [7:0] token_start;
    logic [7:0] token_length;
    logic [7:0] terminator;
    logic       token_empty;
    logic       string_open;
    logic       line_done;

    // scanner shadow state
    logic        in_word;
    scan_class_t mode;
    logic        esc_on;
    logic [7:0]  kept_len;
    logic [7:0]  blank_run;
    logic [7:0]  here_pos;
    logic [7:0]  tok_pos;

    token_t expected_tokens[$];
    int     errors        = 0;
    int     chars_sent    = 0;
    int     lines_sent    = 0;
    int     tokens_seen   = 0;
    int     open_strings  = 0;
    int     empty_tokens  = 0;
    int     send_idle_pct = 0;
    int     stall_pct     = 0;
    bit     hold_go       = 1'b0;
    int     quiet_count   = 0;

    define_value_token_scanner_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_in      (char_in),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token_start  (token_start),
        .token_length (token_length),
        .terminator   (terminator),
        .token_empty  (token_empty),
        .string_open  (string_open),
        .line_done    (line_done)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic bit is_term(input logic [7:0] c);
        return (c == CH_SEMI) || (c == CH_COMMA) || (c == CH_EQUALS);
    endfunction

    function automatic void clear_scan();
        in_word   = 1'b0;
        mode      = CLS_PLAIN;
        esc_on    = 1'b0;
        kept_len  = 8'd0;
        blank_run = 8'd0;
        here_pos  = 8'd0;
        tok_pos   = 8'd0;
    endfunction

    function automatic void bump_pos();
        if (here_pos != POS_MAX)
            here_pos = here_pos + 8'd1;
    endfunction

    // trailing blanks only count once a later non-blank character shows up
    function automatic void absorb(input logic [7:0] c);
        int sum;
        if (is_blank(c))
        begin
            if (blank_run != 8'hFF)
                blank_run = blank_run + 8'd1;
        end
        else
        begin
            sum = int'(kept_len) + int'(blank_run) + 1;
            kept_len  = (sum > int'(LEN_MAX)) ? LEN_MAX : 8'(sum);
            blank_run = 8'd0;
        end
    endfunction

    // advance the shadow scanner by one character, queueing any finished token
    function automatic void scan_predict(input logic [7:0] c);
        token_t t;
        if (c == CH_NUL)
        begin
            t.start  = in_word ? tok_pos : 8'd0;
            t.length = in_word ? kept_len : 8'd0;
            t.term   = CH_NUL;
            t.empty  = !in_word;
            t.sopen  = in_word && (mode == CLS_STRING);
            t.done   = 1'b1;
            expected_tokens.push_back(t);
            clear_scan();
            return;
        end
        if (!in_word)
        begin
            if (is_blank(c))
            begin
                bump_pos();
                return;
            end
            in_word   = 1'b1;
            tok_pos   = here_pos;
            esc_on    = 1'b0;
            kept_len  = 8'd0;
            blank_run = 8'd0;
            if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_LPAREN)
            begin
                mode = (c == CH_DQUOTE) ? CLS_STRING :
                       (c == CH_SQUOTE) ? CLS_LITERAL : CLS_BRACKET;
                absorb(c);
                bump_pos();
                return;
            end
            mode = CLS_PLAIN;
        end
        case (mode)
            CLS_STRING:
            begin
                if (c == CH_BSLASH)
                    esc_on = !esc_on;
                else
                begin
                    if (c == CH_DQUOTE && !esc_on)
                        mode = CLS_PLAIN;
                    esc_on = 1'b0;
                end
            end
            CLS_LITERAL:
            begin
                if (c == CH_SQUOTE)
                    mode = CLS_PLAIN;
            end
            CLS_BRACKET:
            begin
                if (c == CH_RPAREN)
                    mode = CLS_PLAIN;
            end
            default:
            begin
                if (is_term(c))
                begin
                    t.start  = tok_pos;
                    t.length = kept_len;
                    t.term   = c;
                    t.empty  = 1'b0;
                    t.sopen  = 1'b0;
                    t.done   = 1'b0;
                    expected_tokens.push_back(t);
                    in_word   = 1'b0;
                    esc_on    = 1'b0;
                    kept_len  = 8'd0;
                    blank_run = 8'd0;
                    bump_pos();
                    return;
                end
            end
        endcase
        absorb(c);
        bump_pos();
    endfunction

    // one character transfer, occasionally preceded by a pause with char_valid low
    task automatic send_char(input logic [7:0] c);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_in    <= c;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        scan_predict(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_line(input string s);
        send_text(s);
        send_char(CH_NUL);
        lines_sent++;
    endtask

    task automatic send_queue(input logic [7:0] q[$]);
        foreach (q[i])
            send_char(q[i]);
        send_char(CH_NUL);
        lines_sent++;
    endtask

    function automatic logic [7:0] rand_blank();
        return ($urandom_range(1) != 0) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4));
    endfunction

    // random byte, leaning toward the characters the scanner cares about
    function automatic logic [7:0] rand_char();
        logic [7:0] picks[10];
        picks = '{CH_SEMI, CH_COMMA, CH_EQUALS, CH_BSLASH, CH_DQUOTE,
                  CH_LPAREN, CH_RPAREN, CH_SQUOTE, CH_SPACE, CH_TAB};
        if ($urandom_range(99) < 30)
            return picks[$urandom_range(0, 9)];
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic test_empty_lines();
        send_line("");
        send_line(" \t");
        send_text(" ");
        send_char(8'h0B);
        send_char(CH_CR);
        send_line("");
    endtask

    task automatic test_terminator_first();
        send_line(";=,");
        send_line("ab \t;x y,z");
        send_char(8'hFF);
        send_char(8'h80);
        send_line(" =");
    endtask

    task automatic test_string_mode();
        send_line("\"a\\\"b;\"c");
        send_line("\"s\\\\");
        send_line("  \"q;=,");
    endtask

    task automatic test_literal_and_bracket();
        send_line("'x;' = (a,b)");
        send_line("'ab");
        send_line("(x");
    endtask

    // saturation of both the position and the trimmed length
    task automatic test_long_lines();
        logic [7:0] q[$];
        repeat (258) q.push_back(CH_SPACE);
        q.push_back("a");
        q.push_back("b");
        send_queue(q);
        q.delete();
        repeat (200) q.push_back("x");
        repeat (60) q.push_back(CH_SPACE);
        repeat (10) q.push_back("y");
        q.push_back(CH_SEMI);
        q.push_back("z");
        send_queue(q);
    endtask

    // hold the token side off so the scanner backs up into char_stall
    task automatic test_input_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_go       = 1'b1;
        repeat (20) send_text("k;");
        send_line("end");
    endtask

    task automatic test_pause_until_drained();
        send_text("p,q=r;");
        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_tokens.size() != 0);
        send_line("s");
    endtask

    task automatic make_token(ref logic [7:0] q[$], input bit last_tok, output bit left_open);
        int kind;
        logic [7:0] c;
        left_open = 1'b0;
        kind = $urandom_range(0, 3);
        repeat ($urandom_range(0, 2)) q.push_back(rand_blank());
        case (kind)
            0:
            begin
                // plain body: possibly empty so a terminator comes first
                repeat ($urandom_range(0, 5))
                begin
                    do
                        c = rand_char();
                    while (is_term(c));
                    q.push_back(c);
                end
            end
            1:
            begin
                q.push_back(CH_DQUOTE);
                repeat ($urandom_range(0, 5))
                begin
                    c = rand_char();
                    if (c == CH_BSLASH || c == CH_DQUOTE)
                    begin
                        q.push_back(CH_BSLASH);
                        c = rand_char();
                    end
                    q.push_back(c);
                end
                left_open = ($urandom_range(99) < 10);
                if (!left_open)
                    q.push_back(CH_DQUOTE);
            end
            default:
            begin
                q.push_back(kind == 2 ? CH_SQUOTE : CH_LPAREN);
                repeat ($urandom_range(0, 5))
                begin
                    do
                        c = rand_char();
                    while (c == (kind == 2 ? CH_SQUOTE : CH_RPAREN));
                    q.push_back(c);
                end
                left_open = ($urandom_range(99) < 10);
                if (!left_open)
                    q.push_back(kind == 2 ? CH_SQUOTE : CH_RPAREN);
            end
        endcase
        if (!left_open)
        begin
            repeat ($urandom_range(0, 2)) q.push_back(rand_blank());
            if (!last_tok)
                q.push_back(($urandom_range(2) == 0) ? CH_SEMI :
                            ($urandom_range(1) == 0) ? CH_COMMA : CH_EQUALS);
        end
    endtask

    task automatic test_random_lines();
        logic [7:0] q[$];
        int ntok;
        bit open_tail;
        int target;
        target = chars_sent + RANDOM_ITEMS;
        while (chars_sent < target)
        begin
            // a stretch with no idling on either side
            if (chars_sent > target - RANDOM_ITEMS * 3 / 4 &&
                chars_sent < target - RANDOM_ITEMS / 4)
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            else
            begin
                send_idle_pct = IDLE_PCT;
                stall_pct     = IDLE_PCT;
            end
            q.delete();
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(1, 20))
                    q.push_back(($urandom_range(99) < 50) ? rand_char() : 8'($urandom_range(255)));
            end
            else
            begin
                ntok = $urandom_range(0, 4);
                for (int i = 0; i < ntok; i++)
                begin
                    make_token(q, i == ntok - 1, open_tail);
                    if (open_tail)
                        break;
                end
            end
            send_queue(q);
        end
    endtask

    // token side: random stalls, or one long hold-off on request
    initial
    begin
        token_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                token_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_go = 1'b0;
            end
            token_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_tokens
        token_t got;
        token_t want;
        if (rst_n && token_valid && !token_stall)
        begin
            got = '{token_start, token_length, terminator, token_empty, string_open, line_done};
            tokens_seen++;
            if (string_open)
                open_strings++;
            if (token_empty)
                empty_tokens++;
            if (expected_tokens.size() == 0)
            begin
                $display("%0t: unexpected token start=%0d len=%0d term=%h empty=%b open=%b done=%b",
                         $time, got.start, got.length, got.term, got.empty, got.sopen,
                         got.done);
                errors++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (got !== want)
                begin
                    $display("%0t: token mismatch expected start=%0d len=%0d term=%h empty=%b open=%b done=%b",
                             $time, want.start, want.length, want.term, want.empty, want.sopen,
                             want.done);
                    $display("%0t:                actual start=%0d len=%0d term=%h empty=%b open=%b done=%b",
                             $time, got.start, got.length, got.term, got.empty, got.sopen,
                             got.done);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (char_valid && !char_stall) || (token_valid && !token_stall))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d tokens still expected",
                     $time, STALL_LIMIT, expected_tokens.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_in    = 8'h00;
        clear_scan();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_lines();
        test_terminator_first();
        test_string_mode();
        test_literal_and_bracket();
        send_idle_pct = IDLE_PCT;
        stall_pct     = IDLE_PCT;
        test_long_lines();
        test_input_backpressure();
        send_idle_pct = IDLE_PCT;
        stall_pct     = IDLE_PCT;
        test_pause_until_drained();
        test_random_lines();

        char_valid <= 1'b0;
        stall_pct   = IDLE_PCT;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("scanned %0d characters over %0d lines, %0d tokens checked",
                 chars_sent, lines_sent, tokens_seen);
        $display("of those %0d blank-line tokens and %0d with an open string, %0d errors",
                 empty_tokens, open_strings, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
